### hw/rtl/rtp_payload_extract_ring_fifo_defines.svh
// Assertion macros used by rtp_payload_extract_ring_fifo.sv.
// They sample on clk and are disabled while rst is high.
`ifndef RTP_PAYLOAD_EXTRACT_RING_FIFO_DEFINES_SVH
`define RTP_PAYLOAD_EXTRACT_RING_FIFO_DEFINES_SVH

`define RTPX_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtpx assertion failed");

`define RTPX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtpx assertion failed");

`endif

### hw/rtl/rtpx_pkg.sv
package rtpx_pkg;

  localparam int RING_DEPTH       = 4096;
  localparam int RING_AW          = $clog2(RING_DEPTH);
  localparam int CNT_W            = RING_AW + 1;
  localparam int MAX_PACKET_BYTES = 65536;
  localparam int POS_W            = 18;
  localparam int STORED_W         = 13;
  localparam int PAD_BIT          = 5;
  localparam int EXT_BIT          = 4;

  localparam logic [POS_W-1:0] HDR_MAX   = '1;
  localparam logic [POS_W-1:0] HDR_FIXED = POS_W'(12);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_COMMIT = 2'd1,
    ST_DROP   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
    logic       last_of_packet;
  } item_t;

  typedef struct packed {
    logic [7:0]          read_byte;
    logic                read_valid;
    status_t             status;
    logic [STORED_W-1:0] stored_bytes;
  } result_t;

  typedef struct packed {
    logic spoil;
    logic ext_lo;
    logic ext_hi;
    logic pad;
  } flags_t;

endpackage

### hw/rtl/rtp_payload_extract_ring_fifo.sv
// A word accepted on item_ready passes through the input register, then the result register.
// Throughput: one word per cycle while result_ready keeps up; a stalled result word holds the input register.
// The ring is a single memory with one write and one registered read per cycle.
// Reset (rst, synchronous, active high) empties both registers and the ring,
// restores RTP mode, and clears all pointers and counts; no clearing pass is needed.
`include "rtp_payload_extract_ring_fifo_defines.svh"

module rtp_payload_extract_ring_fifo
  import rtpx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic rtp_mode;

  logic  in_full;
  item_t in_q;
  logic  advance;

  logic [RING_AW-1:0] write_head, write_head_next;
  logic [RING_AW-1:0] committed_head, committed_head_next;
  logic [RING_AW-1:0] read_tail, read_tail_next;
  logic [CNT_W-1:0]   committed_count, committed_count_next;
  logic [CNT_W-1:0]   pend_count, pend_count_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [POS_W-1:0]   header_end, header_end_next;
  flags_t             packet_flags, packet_flags_next;

  logic    mem_we;
  logic    mem_re;
  logic [7:0] ring [RING_DEPTH];
  logic [7:0] rd_data;

  status_t status_calc;
  logic    rv_calc;

  logic    res_read_valid;
  status_t res_status;
  logic [STORED_W-1:0] res_stored;

  assign cfg_ready  = 1'b1;
  assign advance    = in_full && (!result_valid || result_ready);
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      rtp_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      rtp_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_q <= item;
    end
  end

  always_comb begin
    logic [7:0]       b;
    logic [POS_W-1:0] p;
    logic [POS_W:0]   ext_sum;
    logic [7:0]       pad;
    logic             keep;

    b = in_q.byte_value;
    p = byte_position;
    ext_sum = '0;
    pad = '0;
    keep = 1'b0;

    write_head_next      = write_head;
    committed_head_next  = committed_head;
    read_tail_next       = read_tail;
    committed_count_next = committed_count;
    pend_count_next      = pend_count;
    byte_position_next   = byte_position;
    header_end_next      = header_end;
    packet_flags_next    = packet_flags;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    status_calc = ST_NONE;
    rv_calc     = 1'b0;

    if (advance) begin
      if (in_q.command == CMD_READ) begin
        if (committed_count != '0) begin
          mem_re               = 1'b1;
          rv_calc              = 1'b1;
          read_tail_next       = read_tail + RING_AW'(1);
          committed_count_next = committed_count - CNT_W'(1);
        end
      end else begin
        if (p >= POS_W'(MAX_PACKET_BYTES)) begin
          packet_flags_next.spoil = 1'b1;
          status_calc = ST_FULL;
        end else begin
          if (p == '0) begin
            packet_flags_next = '0;
            if (rtp_mode) begin
              header_end_next = HDR_FIXED + POS_W'({b[3:0], 2'b00})
                              + (b[EXT_BIT] ? POS_W'(4) : POS_W'(0));
              packet_flags_next.pad    = b[PAD_BIT];
              packet_flags_next.ext_hi = b[EXT_BIT];
            end else begin
              header_end_next = '0;
            end
          end else if (packet_flags.ext_lo) begin
            ext_sum = {1'b0, header_end} + (POS_W+1)'({b, 2'b00});
            header_end_next = ext_sum[POS_W] ? HDR_MAX : ext_sum[POS_W-1:0];
            packet_flags_next.ext_lo = 1'b0;
          end else if (packet_flags.ext_hi && ((p + POS_W'(2)) == header_end)) begin
            ext_sum = {1'b0, header_end} + (POS_W+1)'({b, 10'b0});
            header_end_next = ext_sum[POS_W] ? HDR_MAX : ext_sum[POS_W-1:0];
            packet_flags_next.ext_hi = 1'b0;
            packet_flags_next.ext_lo = 1'b1;
          end

          if (p >= header_end_next) begin
            if (packet_flags_next.spoil) begin
              status_calc = ST_FULL;
            end else if (({1'b0, committed_count} + {1'b0, pend_count})
                         < (CNT_W+1)'(RING_DEPTH)) begin
              mem_we          = 1'b1;
              write_head_next = write_head + RING_AW'(1);
              pend_count_next = pend_count + CNT_W'(1);
            end else begin
              packet_flags_next.spoil = 1'b1;
              status_calc = ST_FULL;
            end
          end
          byte_position_next = p + POS_W'(1);
        end

        if (in_q.last_of_packet) begin
          pad  = packet_flags_next.pad ? b : 8'd0;
          keep = !(packet_flags_next.spoil || packet_flags_next.ext_hi
                   || packet_flags_next.ext_lo)
                 && (byte_position_next >= header_end_next)
                 && (CNT_W'(pad) <= pend_count_next);
          if (keep) begin
            write_head_next      = write_head_next - RING_AW'(pad);
            committed_count_next = committed_count + pend_count_next - CNT_W'(pad);
            committed_head_next  = write_head_next;
            status_calc = ST_COMMIT;
          end else begin
            write_head_next = committed_head;
            status_calc = ST_DROP;
          end
          byte_position_next = '0;
          header_end_next    = HDR_FIXED;
          packet_flags_next  = '0;
          pend_count_next    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_head      <= '0;
      committed_head  <= '0;
      read_tail       <= '0;
      committed_count <= '0;
      pend_count      <= '0;
      byte_position   <= '0;
      header_end      <= HDR_FIXED;
      packet_flags    <= '0;
    end else begin
      write_head      <= write_head_next;
      committed_head  <= committed_head_next;
      read_tail       <= read_tail_next;
      committed_count <= committed_count_next;
      pend_count      <= pend_count_next;
      byte_position   <= byte_position_next;
      header_end      <= header_end_next;
      packet_flags    <= packet_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[write_head] <= in_q.byte_value;
    end
    if (mem_re) begin
      rd_data <= ring[read_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_read_valid <= rv_calc;
      res_status     <= status_calc;
      res_stored     <= STORED_W'(committed_count_next);
    end
  end

  assign result.read_byte    = res_read_valid ? rd_data : 8'd0;
  assign result.read_valid   = res_read_valid;
  assign result.status       = res_status;
  assign result.stored_bytes = res_stored;

  `RTPX_ASSERT_SAME(a_count_bound, 1'b1, committed_count <= CNT_W'(RING_DEPTH))
  `RTPX_ASSERT_SAME(a_pend_bound, 1'b1, ({1'b0, committed_count} + {1'b0, pend_count}) <= (CNT_W+1)'(RING_DEPTH))
  `RTPX_ASSERT_NEXT(a_stall_holds, result_valid && !result_ready, $stable(committed_count) && $stable(write_head))
  `RTPX_ASSERT_SAME(a_read_no_status, result_valid && result.read_valid, result.status == ST_NONE)

endmodule

### verif/rtp_payload_extract_ring_fifo_monitor.sv
`timescale 1ns / 100ps

module rtp_payload_extract_ring_fifo_monitor
  import rtpx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        item_valid,
  input  logic        item_ready,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  output int unsigned fail_count,
  output int unsigned words_due
);

  logic [7:0]         ring [RING_DEPTH];
  logic [RING_AW-1:0] wr_head;
  logic [RING_AW-1:0] kept_head;
  logic [RING_AW-1:0] rd_tail;
  logic [CNT_W-1:0]   kept_bytes;
  int unsigned        pos;
  int unsigned        hdr_end;
  flags_t             flags;
  logic               strip_rtp;
  result_t            due_outputs[$];
  int unsigned        mismatches = 0;

  assign fail_count = mismatches;

  task automatic depacketize(input item_t w, output result_t r);
    int unsigned p;
    int unsigned grown;
    int unsigned payload;
    int unsigned pad;
    logic        keep;
    status_t     st;
    r = '0;
    st = ST_NONE;
    if (w.command == CMD_READ) begin
      if (kept_bytes != 0) begin
        r.read_byte = ring[rd_tail];
        r.read_valid = 1'b1;
        rd_tail = rd_tail + 1'b1;
        kept_bytes = kept_bytes - 1'b1;
      end
    end else begin
      p = pos;
      if (p >= MAX_PACKET_BYTES) begin
        flags.spoil = 1'b1;
        st = ST_FULL;
      end else begin
        if (p == 0) begin
          flags = '0;
          if (strip_rtp) begin
            hdr_end = 12 + 4 * w.byte_value[3:0];
            flags.pad = w.byte_value[PAD_BIT];
            if (w.byte_value[EXT_BIT]) begin
              hdr_end = hdr_end + 4;
              flags.ext_hi = 1'b1;
            end
          end else begin
            hdr_end = 0;
          end
        end else if (flags.ext_lo) begin
          grown = hdr_end + 4 * w.byte_value;
          hdr_end = (grown > HDR_MAX) ? HDR_MAX : grown;
          flags.ext_lo = 1'b0;
        end else if (flags.ext_hi && p + 2 == hdr_end) begin
          grown = hdr_end + 1024 * w.byte_value;
          hdr_end = (grown > HDR_MAX) ? HDR_MAX : grown;
          flags.ext_hi = 1'b0;
          flags.ext_lo = 1'b1;
        end
        if (p >= hdr_end) begin
          if (flags.spoil) begin
            st = ST_FULL;
          end else if (kept_bytes + (p - hdr_end) < RING_DEPTH) begin
            ring[wr_head] = w.byte_value;
            wr_head = wr_head + 1'b1;
          end else begin
            flags.spoil = 1'b1;
            st = ST_FULL;
          end
        end
        pos = p + 1;
      end
      if (w.last_of_packet) begin
        keep = 1'b1;
        payload = 0;
        pad = 0;
        if (flags.spoil || flags.ext_hi || flags.ext_lo || pos < hdr_end) begin
          keep = 1'b0;
        end else begin
          payload = pos - hdr_end;
          pad = flags.pad ? w.byte_value : 0;
          if (pad > payload) keep = 1'b0;
        end
        if (keep) begin
          wr_head = wr_head - pad[RING_AW-1:0];
          kept_bytes = kept_bytes + CNT_W'(payload - pad);
          kept_head = wr_head;
          st = ST_COMMIT;
        end else begin
          wr_head = kept_head;
          st = ST_DROP;
        end
        pos = 0;
        hdr_end = HDR_FIXED;
        flags = '0;
      end
    end
    r.status = st;
    r.stored_bytes = kept_bytes;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      wr_head = '0;
      kept_head = '0;
      rd_tail = '0;
      kept_bytes = '0;
      pos = 0;
      hdr_end = HDR_FIXED;
      flags = '0;
      strip_rtp = 1'b1;
      due_outputs.delete();
      words_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) strip_rtp = cfg_data;
      if (item_valid && item_ready) begin
        depacketize(item, want);
        due_outputs.push_back(want);
      end
      if (result_valid && result_ready) begin
        if (due_outputs.size() == 0) begin
          $error("result word arrived with no prediction pending");
          mismatches++;
        end else begin
          want = due_outputs.pop_front();
          if (result.read_byte !== want.read_byte) begin
            $error("read_byte: expected %0d, got %0d", want.read_byte, result.read_byte);
            mismatches++;
          end
          if (result.read_valid !== want.read_valid) begin
            $error("read_valid: expected %0d, got %0d", want.read_valid, result.read_valid);
            mismatches++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            mismatches++;
          end
          if (result.stored_bytes !== want.stored_bytes) begin
            $error("stored_bytes: expected %0d, got %0d", want.stored_bytes,
                   result.stored_bytes);
            mismatches++;
          end
        end
      end
      words_due <= due_outputs.size();
    end
  end

endmodule

### verif/rtp_payload_extract_ring_fifo_tb.sv
`timescale 1ns / 100ps

module rtp_payload_extract_ring_fifo_tb;
  import rtpx_pkg::*;

  typedef enum int {PAD_NONE, PAD_GOOD, PAD_ZERO, PAD_OVER} pad_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  int unsigned fail_count;
  int unsigned words_due;
  logic        long_hold_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  logic [7:0]  pkt[$];

  always #1 clk = ~clk;

  rtp_payload_extract_ring_fifo i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  rtp_payload_extract_ring_fifo_monitor i_monitor (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .words_due    (words_due)
  );

  task automatic push_word(input item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    items_sent++;
  endtask

  task automatic send_read();
    item_t w;
    w.command = CMD_READ;
    w.byte_value = 8'($urandom);
    w.last_of_packet = 1'($urandom);
    push_word(w);
  endtask

  task automatic send_bytes(input int first, input int count, input bit close,
                            input int read_odds);
    item_t w;
    for (int k = first; k < first + count; k++) begin
      if (read_odds != 0 && $urandom_range(1, read_odds) == 1) send_read();
      w.command = CMD_WRITE;
      w.byte_value = pkt[k];
      w.last_of_packet = close && (k == first + count - 1);
      push_word(w);
    end
  endtask

  task automatic random_bytes(input int n);
    pkt.delete();
    repeat (n) pkt.push_back(8'($urandom));
  endtask

  task automatic build_rtp(input int cc, input bit ext, input logic [15:0] ext_words,
                           input int pay_len, input pad_kind_t pad_kind);
    logic [7:0] b0;
    int         lim;
    pkt.delete();
    b0 = 8'($urandom);
    b0[PAD_BIT] = (pad_kind != PAD_NONE);
    b0[EXT_BIT] = ext;
    b0[3:0] = 4'(cc);
    pkt.push_back(b0);
    repeat (11 + 4 * cc) pkt.push_back(8'($urandom));
    if (ext) begin
      repeat (2) pkt.push_back(8'($urandom));
      pkt.push_back(ext_words[15:8]);
      pkt.push_back(ext_words[7:0]);
      // Long extensions are cut short, so such packets mostly end as drops.
      repeat ((4 * ext_words > 64) ? 64 : 4 * ext_words) pkt.push_back(8'($urandom));
    end
    repeat (pay_len) pkt.push_back(8'($urandom));
    if (pay_len > 0) begin
      case (pad_kind)
        PAD_GOOD: begin
          lim = (pay_len > 255) ? 255 : pay_len;
          pkt[pkt.size() - 1] = 8'($urandom_range(1, lim));
        end
        PAD_ZERO: pkt[pkt.size() - 1] = 8'h00;
        PAD_OVER: begin
          if (pay_len < 255) pkt[pkt.size() - 1] = 8'($urandom_range(pay_len + 1, 255));
        end
        default: ;
      endcase
    end
  endtask

  task automatic random_rtp_packet();
    int          cc;
    bit          ext;
    logic [15:0] ext_words;
    int          pay_len;
    int          r;
    int          cut;
    pad_kind_t   pk;
    cc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
    ext = ($urandom_range(0, 2) == 0);
    ext_words = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    pay_len = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 40);
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4, 5: pk = PAD_NONE;
      6, 7: pk = PAD_GOOD;
      8: pk = PAD_ZERO;
      default: pk = PAD_OVER;
    endcase
    build_rtp(cc, ext, ext_words, pay_len, pk);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  task automatic rtp_traffic(input int n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 12) random_bytes($urandom_range(1, 30));
      else random_rtp_packet();
      send_bytes(0, pkt.size(), 1'b1, 8);
      repeat ($urandom_range(0, 40)) send_read();
    end
  endtask

  task automatic raw_traffic(input int n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) begin
      random_bytes($urandom_range(1, 60));
      send_bytes(0, pkt.size(), 1'b1, 8);
      repeat ($urandom_range(0, 60)) send_read();
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned run_left;
    logic        run_on;
    int unsigned hold_left;
    logic        hold_done;
    run_left = 0;
    run_on = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
        result_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_on = !run_on;
          run_left = run_on ? $urandom_range(1, 40) : $urandom_range(1, 6);
        end
        run_left--;
        result_ready <= run_on;
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_read();
    pkt = {8'h80, 8'h60, 8'h00, 8'h01};
    send_bytes(0, pkt.size(), 1'b1, 0);
    build_rtp(0, 1'b0, 16'h0000, 1, PAD_GOOD);
    send_bytes(0, pkt.size(), 1'b1, 0);
    send_read();

    long_hold_req <= 1'b1;
    rtp_traffic(330);

    // The mode changes in the middle of a packet; the packet keeps the mode of its
    // first byte.
    build_rtp(1, 1'b0, 16'h0000, 20, PAD_NONE);
    send_bytes(0, 10, 1'b0, 0);
    wait_idle();
    set_mode(1'b0);
    send_bytes(10, pkt.size() - 10, 1'b1, 0);
    raw_traffic(190);

    wait_idle();
    set_mode(1'b1);
    build_rtp(15, 1'b1, 16'hFFFF, 0, PAD_NONE);
    send_bytes(0, pkt.size(), 1'b1, 0);
    rtp_traffic(170);

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[rtp_payload_extract_ring_fifo] OK");
    end else begin
      $display("[rtp_payload_extract_ring_fifo] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("[rtp_payload_extract_ring_fifo] ERROR");
    $finish;
  end

endmodule
